@@ rtl/occupancy_grid_ray_update_macros.svh @@
// ----------------------------------------------------------------------------
// Occupancy grid ray update: assertion macros
// Concurrent assertion wrappers clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_RAY_UPDATE_MACROS_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_MACROS_SVH

// property that holds at every edge outside reset
`define OGRU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ogru check failed");

// same-cycle implication
`define OGRU_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("ogru check failed");

// next-cycle implication
`define OGRU_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ogru check failed");

`endif

@@ rtl/ogru_pkg.sv @@
// ----------------------------------------------------------------------------
// Occupancy grid ray update package
// Grid geometry, coordinate widths, cell operation codes and shared helpers.
// ----------------------------------------------------------------------------
package ogru_pkg;

    localparam int GRID_COLS  = 512;
    localparam int GRID_ROWS  = 512;
    localparam int DEPTH      = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ROW_W      = $clog2(GRID_ROWS);

    localparam logic [7:0] UNKNOWN_VALUE = 8'd127;
    localparam logic [7:0] CELL_MAX      = 8'd255;
    localparam logic [7:0] CELL_MIN      = 8'd0;
    localparam logic [7:0] CLASS_MID     = 8'd127;

    // coordinate, delta and remainder widths for 16-bit signed endpoints
    localparam int CRD_W = 18;
    localparam int LEN_W = 17;
    localparam int REM_W = 19;

    typedef enum logic [1:0] {
        OP_RAY  = 2'd0,
        OP_MARK = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CFG_MAP_COLS = 2'd0,
        CFG_MAP_ROWS = 2'd1,
        CFG_OBSTACLE = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CELL_FREE = 2'd0,
        CELL_HIT  = 2'd1,
        CELL_MARK = 2'd2,
        CELL_READ = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic                valid;
        t_cell_op            kind;
        logic [ADDR_W-1:0]   addr;
        logic [7:0]          wdata;
    } t_cell_req;

    typedef struct packed {
        logic       clearing;
        logic       rd_valid;
        logic [7:0] rd_data;
    } t_mem_stat;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
    } t_ray;

    typedef struct packed {
        logic [CRD_W-1:0] cols;
        logic [CRD_W-1:0] rows;
    } t_map_lim;

    function automatic logic inside_map(input logic signed [CRD_W-1:0] x,
                                        input logic signed [CRD_W-1:0] y,
                                        input t_map_lim lim);
        return !x[CRD_W-1] && !y[CRD_W-1] &&
               ($unsigned(x) < lim.cols) && ($unsigned(y) < lim.rows);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [CRD_W-1:0] x,
                                                    input logic signed [CRD_W-1:0] y);
        return ADDR_W'(ADDR_W'(y[ROW_W-1:0]) * ADDR_W'(GRID_COLS)) +
               ADDR_W'(x[COL_W-1:0]);
    endfunction

endpackage

@@ rtl/ogru_ray_walker.sv @@
// ----------------------------------------------------------------------------
// Ray walker
// Steps along the major axis one cell per cycle and tracks the minor axis as
// an exact rational floor (quotient plus remainder), then issues the hit cell.
// ----------------------------------------------------------------------------
module ogru_ray_walker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ogru_pkg::t_ray     i_ray,
    input  ogru_pkg::t_map_lim i_lim,
    output ogru_pkg::t_cell_req o_req,
    output logic               o_done
);

    typedef enum logic [2:0] {
        W_IDLE = 3'b001,
        W_WALK = 3'b010,
        W_HIT  = 3'b100
    } t_wstate;

    t_wstate r_state, n_state;

    logic signed [ogru_pkg::CRD_W-1:0] r_maj, n_maj;
    logic signed [ogru_pkg::CRD_W-1:0] r_min, n_min;
    logic signed [ogru_pkg::CRD_W-1:0] r_dmin, n_dmin;
    logic signed [ogru_pkg::REM_W-1:0] r_rem, n_rem;
    logic [ogru_pkg::LEN_W-1:0]        r_len, n_len;
    logic [ogru_pkg::LEN_W-1:0]        r_k, n_k;
    logic                              r_maj_neg, n_maj_neg;
    logic                              r_y_major, n_y_major;
    logic signed [ogru_pkg::CRD_W-1:0] r_ex, n_ex;
    logic signed [ogru_pkg::CRD_W-1:0] r_ey, n_ey;

    logic signed [ogru_pkg::CRD_W-1:0] sx_w, sy_w, ex_w, ey_w, dx, dy;
    logic [ogru_pkg::LEN_W-1:0]        adx, ady;
    logic                              y_major;
    logic signed [ogru_pkg::REM_W-1:0] rem_sum, len_s;
    logic signed [ogru_pkg::CRD_W-1:0] cx, cy;

    always_comb begin
        sx_w    = ogru_pkg::CRD_W'(i_ray.sx);
        sy_w    = ogru_pkg::CRD_W'(i_ray.sy);
        ex_w    = ogru_pkg::CRD_W'(i_ray.ex);
        ey_w    = ogru_pkg::CRD_W'(i_ray.ey);
        dx      = ex_w - sx_w;
        dy      = ey_w - sy_w;
        adx     = dx[ogru_pkg::CRD_W-1] ? ogru_pkg::LEN_W'(-dx) : ogru_pkg::LEN_W'(dx);
        ady     = dy[ogru_pkg::CRD_W-1] ? ogru_pkg::LEN_W'(-dy) : ogru_pkg::LEN_W'(dy);
        // ties go to the y axis
        y_major = (ady >= adx);

        rem_sum = r_rem + ogru_pkg::REM_W'(r_dmin);
        len_s   = signed'(ogru_pkg::REM_W'(r_len));
        cx      = r_y_major ? r_min : r_maj;
        cy      = r_y_major ? r_maj : r_min;
    end

    always_comb begin
        n_state   = r_state;
        n_maj     = r_maj;
        n_min     = r_min;
        n_dmin    = r_dmin;
        n_rem     = r_rem;
        n_len     = r_len;
        n_k       = r_k;
        n_maj_neg = r_maj_neg;
        n_y_major = r_y_major;
        n_ex      = r_ex;
        n_ey      = r_ey;
        o_req     = '0;
        o_done    = 1'b0;

        unique case (r_state)
            W_IDLE: begin
                if (i_start) begin
                    n_y_major = y_major;
                    n_maj     = y_major ? sy_w : sx_w;
                    n_min     = y_major ? sx_w : sy_w;
                    n_dmin    = y_major ? dx : dy;
                    n_maj_neg = y_major ? dy[ogru_pkg::CRD_W-1] : dx[ogru_pkg::CRD_W-1];
                    n_len     = y_major ? ady : adx;
                    n_rem     = '0;
                    n_k       = '0;
                    n_ex      = ex_w;
                    n_ey      = ey_w;
                    n_state   = W_WALK;
                end
            end
            W_WALK: begin
                o_req.valid = ogru_pkg::inside_map(cx, cy, i_lim);
                o_req.kind  = ogru_pkg::CELL_FREE;
                o_req.addr  = ogru_pkg::cell_addr(cx, cy);
                n_maj = r_maj_neg ? r_maj - ogru_pkg::CRD_W'(1) : r_maj + ogru_pkg::CRD_W'(1);
                // remainder stays in [0, len): one correction step suffices
                if (rem_sum >= len_s) begin
                    n_rem = rem_sum - len_s;
                    n_min = r_min + ogru_pkg::CRD_W'(1);
                end else if (rem_sum[ogru_pkg::REM_W-1]) begin
                    n_rem = rem_sum + len_s;
                    n_min = r_min - ogru_pkg::CRD_W'(1);
                end else begin
                    n_rem = rem_sum;
                end
                n_k = r_k + ogru_pkg::LEN_W'(1);
                if (r_k == ogru_pkg::LEN_W'(r_len - ogru_pkg::LEN_W'(1))) begin
                    n_state = W_HIT;
                end
            end
            W_HIT: begin
                o_req.valid = ogru_pkg::inside_map(r_ex, r_ey, i_lim);
                o_req.kind  = ogru_pkg::CELL_HIT;
                o_req.addr  = ogru_pkg::cell_addr(r_ex, r_ey);
                o_done      = 1'b1;
                n_state     = W_IDLE;
            end
            default: n_state = W_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_maj     <= n_maj;
        r_min     <= n_min;
        r_dmin    <= n_dmin;
        r_rem     <= n_rem;
        r_len     <= n_len;
        r_k       <= n_k;
        r_maj_neg <= n_maj_neg;
        r_y_major <= n_y_major;
        r_ex      <= n_ex;
        r_ey      <= n_ey;
    end

endmodule

@@ rtl/ogru_cell_mem.sv @@
// ----------------------------------------------------------------------------
// Cell store
// Grid memory with a two-stage read-modify-write path (read, then saturate
// or overwrite and write back) and a clearing sweep to the unknown value after reset.
// ----------------------------------------------------------------------------
module ogru_cell_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ogru_pkg::t_cell_req i_req,
    output ogru_pkg::t_mem_stat o_stat
);

    logic [7:0] r_mem [ogru_pkg::DEPTH];
    logic [7:0] r_rdata;

    logic                        r_s1_valid;
    ogru_pkg::t_cell_op          r_s1_kind;
    logic [ogru_pkg::ADDR_W-1:0] r_s1_addr;
    logic [7:0]                  r_s1_wdata;

    logic                        r_clr_busy;
    logic [ogru_pkg::ADDR_W-1:0] r_clr_addr;

    logic [7:0] n_cell;

    always_comb begin
        case (r_s1_kind)
            ogru_pkg::CELL_FREE:
                n_cell = (r_rdata == ogru_pkg::CELL_MAX) ? r_rdata : r_rdata + 8'd1;
            ogru_pkg::CELL_HIT:
                n_cell = (r_rdata == ogru_pkg::CELL_MIN) ? r_rdata : r_rdata - 8'd1;
            ogru_pkg::CELL_MARK:
                n_cell = r_s1_wdata;
            default:
                n_cell = r_rdata;
        endcase
    end

    // read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.addr];
    end

    // write port: clearing sweep first, then write-back
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= ogru_pkg::UNKNOWN_VALUE;
        end else if (r_s1_valid && (r_s1_kind != ogru_pkg::CELL_READ)) begin
            r_mem[r_s1_addr] <= n_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_s1_valid <= i_req.valid;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ogru_pkg::ADDR_W'(1);
                if (r_clr_addr == ogru_pkg::ADDR_W'(ogru_pkg::DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
        r_s1_kind  <= i_req.kind;
        r_s1_addr  <= i_req.addr;
        r_s1_wdata <= i_req.wdata;
    end

    assign o_stat.clearing = r_clr_busy;
    assign o_stat.rd_valid = r_s1_valid && (r_s1_kind == ogru_pkg::CELL_READ);
    assign o_stat.rd_data  = r_rdata;

endmodule

@@ rtl/occupancy_grid_ray_update.sv @@
// ----------------------------------------------------------------------------
// Occupancy grid ray update
// 8-bit occupancy grid with ray, obstacle mark and cell read operations.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction; m_axis returns exactly one
//   result per operation, in order. The cfg channel writes map_cols,
//   map_rows and obstacle_value (always ready; write only while idle).
//   Operations run one at a time. A ray goes from acceptance to its result
//   through a setup state, a walk along the major axis, one cell a cycle
//   (up to 65535 cells for endpoints far off the map), through the walker
//   and the memory's single read-modify-write path, the hit cell, loading
//   the output register and presenting it on m_axis. A zero-length ray or
//   a mark skips the walk, an in-map read waits for the memory's read data;
//   the next operation can be accepted at the same edge as the result is taken.
//   After reset the memory sweeps every cell to the unknown value, one cell a
//   cycle (all 262144 cells of the grid); s_axis_tready stays low until the
//   sweep ends. A stalled m_axis holds its result in the output register;
//   the next operation is still accepted and runs, and waits only for the
//   output register to free up before presenting its own result.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] op, [17:2] start_x, [33:18] start_y, [49:34] end_x,
    // [65:50] end_y, [71:66] zero
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] cell_value, [15:8] cell_class, [16] in_map, [23:17] zero
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_WALK   = 5'b00100,
        S_WAITRD = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]         r_op;
    ogru_pkg::t_ray     r_ray;
    logic [9:0]         r_cols, r_rows;
    logic [7:0]         r_obst;
    logic [7:0]         r_value, n_value;
    logic [7:0]         r_class, n_class;
    logic               r_in_map, n_in_map;
    logic               r_out_valid, n_out_valid;
    logic [23:0]        r_out_data, n_out_data;

    ogru_pkg::t_map_lim  lim;
    ogru_pkg::t_cell_req walk_req, top_req, mem_req;
    ogru_pkg::t_mem_stat mem_stat;
    logic                walk_start, walk_done;
    logic                end_in, zero_ray, in_take;
    logic signed [ogru_pkg::CRD_W-1:0] ex_w, ey_w;

    assign lim.cols = (r_cols > ogru_pkg::GRID_COLS) ? ogru_pkg::CRD_W'(ogru_pkg::GRID_COLS)
                                                     : ogru_pkg::CRD_W'(r_cols);
    assign lim.rows = (r_rows > ogru_pkg::GRID_ROWS) ? ogru_pkg::CRD_W'(ogru_pkg::GRID_ROWS)
                                                     : ogru_pkg::CRD_W'(r_rows);

    assign ex_w     = ogru_pkg::CRD_W'(r_ray.ex);
    assign ey_w     = ogru_pkg::CRD_W'(r_ray.ey);
    assign end_in   = ogru_pkg::inside_map(ex_w, ey_w, lim);
    assign zero_ray = (r_ray.sx == r_ray.ex) && (r_ray.sy == r_ray.ey);

    assign s_axis_tready = (r_state == S_IDLE) && !mem_stat.clearing;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_class     = r_class;
        n_in_map    = r_in_map;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        walk_start  = 1'b0;
        top_req     = '0;
        top_req.addr  = ogru_pkg::cell_addr(ex_w, ey_w);
        top_req.wdata = r_obst;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_value  = '0;
                n_class  = '0;
                n_in_map = end_in;
                n_state  = S_RESULT;
                case (r_op)
                    ogru_pkg::OP_RAY: begin
                        if (!zero_ray) begin
                            walk_start = 1'b1;
                            n_state    = S_WALK;
                        end
                    end
                    ogru_pkg::OP_MARK: begin
                        top_req.valid = end_in;
                        top_req.kind  = ogru_pkg::CELL_MARK;
                    end
                    ogru_pkg::OP_READ: begin
                        top_req.valid = end_in;
                        top_req.kind  = ogru_pkg::CELL_READ;
                        if (end_in) begin
                            n_state = S_WAITRD;
                        end
                    end
                    default: ;
                endcase
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = S_RESULT;
                end
            end
            S_WAITRD: begin
                if (mem_stat.rd_valid) begin
                    n_value = mem_stat.rd_data;
                    if (mem_stat.rd_data == ogru_pkg::CLASS_MID) begin
                        n_class = ogru_pkg::CLASS_MID;
                    end else if (mem_stat.rd_data > ogru_pkg::CLASS_MID) begin
                        n_class = ogru_pkg::CELL_MAX;
                    end else begin
                        n_class = ogru_pkg::CELL_MIN;
                    end
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, r_in_map, r_class, r_value};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign mem_req = walk_req.valid ? walk_req : top_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cols      <= 10'd512;
            r_rows      <= 10'd512;
            r_obst      <= 8'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    ogru_pkg::CFG_MAP_COLS: r_cols <= i_cfg_data;
                    ogru_pkg::CFG_MAP_ROWS: r_rows <= i_cfg_data;
                    ogru_pkg::CFG_OBSTACLE: r_obst <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        if (in_take) begin
            r_op     <= s_axis_tdata[1:0];
            r_ray.sx <= s_axis_tdata[17:2];
            r_ray.sy <= s_axis_tdata[33:18];
            r_ray.ex <= s_axis_tdata[49:34];
            r_ray.ey <= s_axis_tdata[65:50];
        end
        r_value    <= n_value;
        r_class    <= n_class;
        r_in_map   <= n_in_map;
        r_out_data <= n_out_data;
    end

    ogru_ray_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (walk_start),
        .i_ray   (r_ray),
        .i_lim   (lim),
        .o_req   (walk_req),
        .o_done  (walk_done)
    );

    ogru_cell_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_stat  (mem_stat)
    );

endmodule

@@ rtl/ogru_checker.sv @@
// ----------------------------------------------------------------------------
// Occupancy grid ray update checker
// Port-level checks on the result stream and the one-at-a-time operation flow.
// ----------------------------------------------------------------------------
`include "occupancy_grid_ray_update_macros.svh"

module ogru_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic [7:0] res_value, res_class;
    logic       res_in_map;

    assign res_value  = m_axis_tdata[7:0];
    assign res_class  = m_axis_tdata[15:8];
    assign res_in_map = m_axis_tdata[16];

    // a stalled result stays presented
    `OGRU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // one operation at a time: no second transaction right after one
    `OGRU_ASSERT_NEXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a cell outside the map reports no value and no class
    `OGRU_ASSERT_IMPL(a_outside_zero, m_axis_tvalid && !res_in_map,
                      res_value == 8'd0 && res_class == 8'd0)

    // class agrees with the value's relation to the midpoint
    `OGRU_ASSERT(a_class_match, !m_axis_tvalid ||
                 (res_value < 8'd127 && res_class == 8'd0) ||
                 (res_value == 8'd127 && res_class == 8'd127) ||
                 (res_value > 8'd127 && res_class == 8'd255))

endmodule

bind occupancy_grid_ray_update ogru_checker u_ogru_checker (.*);
